>>> hw/rtl/fcsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcsd_pkg;

	localparam logic [7:0] FR_END       = 8'hC0;
	localparam logic [7:0] FR_ESC       = 8'hDB;
	localparam logic [7:0] FR_TEND      = 8'hDC;
	localparam logic [7:0] FR_TESC      = 8'hDD;
	localparam logic [7:0] CHR_SPACE    = 8'h20;
	localparam logic [7:0] CHR_TILDE    = 8'h7E;
	localparam logic [7:0] CHR_TAB      = 8'h09;
	localparam logic [7:0] CHR_LF       = 8'h0A;
	localparam logic [7:0] CHR_CR       = 8'h0D;
	localparam logic [7:0] CHR_LBRACE   = 8'h7B;
	localparam logic [7:0] CHR_LBRACKET = 8'h5B;
	localparam logic [2:0] HEAD_LEN     = 3'd4;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic [1:0] {
		CLASS_SLIP  = 2'd0,
		CLASS_JSON  = 2'd1,
		CLASS_PROTO = 2'd2,
		CLASS_TEXT  = 2'd3
	} class_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       frame_end;
	} in_item_t;

	typedef struct packed {
		logic        out_kind;
		logic [7:0]  out_byte;
		logic [1:0]  frame_class;
		logic [15:0] decoded_count;
		logic        run_end;
	} out_item_t;

	// work handed from the classifier to the output side
	typedef struct packed {
		logic        has_byte;
		logic [7:0]  byte_val;
		logic        has_report;
		class_t      frame_class;
		logic [15:0] count;
	} cmd_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_CR) || (c == CHR_LF);
	endfunction

	function automatic logic is_printable(input logic [7:0] c);
		return ((c >= CHR_SPACE) && (c <= CHR_TILDE)) ||
			(c == CHR_TAB) || (c == CHR_LF) || (c == CHR_CR);
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fcsd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fcsd_front import fcsd_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     byte_valid,
	output logic          byte_stall,
	input  wire in_item_t byte_data,
	output logic          push,
	output cmd_t          push_cmd,
	input  wire logic     full
);

	logic [2:0]             pos_q;
	logic                   slip_q, closed_q, esc_q, nonspace_q, json_q, nontext_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	logic                   accept, last;
	logic [7:0]             b;
	logic                   slip_now, nonspace_now, json_now, nontext_now;
	logic                   closed_next, esc_next, emit;
	logic [7:0]             val;
	logic [COUNT_WIDTH-1:0] cnt_next;
	class_t                 cls;

	assign byte_stall = full;
	assign accept     = byte_valid && !full;
	assign b          = byte_data.in_byte;
	assign last       = byte_data.frame_end;

	always_comb begin
		slip_now     = (pos_q == 3'd0) ? (b == FR_END) : slip_q;
		nonspace_now = nonspace_q || !is_space(b);
		json_now     = nonspace_q ? json_q
			: (!is_space(b) && ((b == CHR_LBRACE) || (b == CHR_LBRACKET)));
		nontext_now  = nontext_q || ((pos_q < HEAD_LEN) && !is_printable(b));

		closed_next = closed_q;
		esc_next    = esc_q;
		emit        = 1'b0;
		val         = b;
		if (slip_now && (pos_q != 3'd0) && !closed_q) begin
			if (esc_q) begin
				esc_next = 1'b0;
				emit     = 1'b1;
				if (b == FR_TEND)
					val = FR_END;
				else if (b == FR_TESC)
					val = FR_ESC;
			end else if (b == FR_END) begin
				closed_next = 1'b1;
			end else if (b == FR_ESC) begin
				esc_next = 1'b1;
			end else begin
				emit = 1'b1;
			end
		end

		cnt_next = (emit && (cnt_q != '1)) ? cnt_q + COUNT_WIDTH'(1) : cnt_q;

		if (slip_now)
			cls = CLASS_SLIP;
		else if (json_now)
			cls = CLASS_JSON;
		else if ((pos_q != 3'd0) && nontext_now)
			cls = CLASS_PROTO;
		else
			cls = CLASS_TEXT;

		push                 = accept && (emit || last);
		push_cmd.has_byte    = emit;
		push_cmd.byte_val    = val;
		push_cmd.has_report  = last;
		push_cmd.frame_class = cls;
		push_cmd.count       = 16'(cnt_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= 3'd0;
			slip_q     <= 1'b0;
			closed_q   <= 1'b0;
			esc_q      <= 1'b0;
			nonspace_q <= 1'b0;
			json_q     <= 1'b0;
			nontext_q  <= 1'b0;
			cnt_q      <= '0;
		end else if (accept) begin
			if (last) begin
				// frame done: back to the idle state for the next one
				pos_q      <= 3'd0;
				slip_q     <= 1'b0;
				closed_q   <= 1'b0;
				esc_q      <= 1'b0;
				nonspace_q <= 1'b0;
				json_q     <= 1'b0;
				nontext_q  <= 1'b0;
				cnt_q      <= '0;
			end else begin
				pos_q      <= (pos_q < HEAD_LEN) ? pos_q + 3'd1 : pos_q;
				slip_q     <= slip_now;
				closed_q   <= closed_next;
				esc_q      <= esc_next;
				nonspace_q <= nonspace_now;
				json_q     <= json_now;
				nontext_q  <= nontext_now;
				cnt_q      <= cnt_next;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/fcsd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fcsd_queue import fcsd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	output logic      head_valid,
	output cmd_t      head_cmd,
	input  wire logic pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   level_q;

	assign full       = (level_q == (PW + 1)'(DEPTH));
	assign head_valid = (level_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				level_q <= level_q + (PW + 1)'(1);
			else if (pop && !push)
				level_q <= level_q - (PW + 1)'(1);
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/fcsd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fcsd_back import fcsd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire cmd_t head_cmd,
	output logic      pop,
	output logic      result_valid,
	input  wire logic result_stall,
	output out_item_t result_data
);

	logic      valid_q;
	logic      phase_q;
	out_item_t data_q;
	logic      load, send_byte;
	out_item_t next_item;

	assign result_valid = valid_q;
	assign result_data  = data_q;

	always_comb begin
		load      = head_valid && (!valid_q || !result_stall);
		send_byte = head_cmd.has_byte && !phase_q;
		if (send_byte) begin
			next_item.out_kind      = KIND_BYTE;
			next_item.out_byte      = head_cmd.byte_val;
			next_item.frame_class   = CLASS_SLIP;
			next_item.decoded_count = 16'd0;
			next_item.run_end       = !head_cmd.has_report;
		end else begin
			next_item.out_kind      = KIND_REPORT;
			next_item.out_byte      = 8'd0;
			next_item.frame_class   = head_cmd.frame_class;
			next_item.decoded_count = head_cmd.count;
			next_item.run_end       = 1'b1;
		end
		// retire the entry once its last result goes out
		pop = load && !(send_byte && head_cmd.has_report);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (!result_stall)
				valid_q <= 1'b0;
			if (load)
				phase_q <= !pop;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= next_item;
	end

endmodule

`default_nettype wire

>>> hw/rtl/frame_classifier_slip_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload (fcsd_pkg)  Handshake
// byte      in         in_item_t           byte_valid / byte_stall
// result    out        out_item_t          result_valid / result_stall
//
// One byte is taken per cycle while the queue is not full; classification
// and SLIP decode happen in the same cycle the byte is accepted. The work
// then goes through a small queue to the output register, which sends one
// result per cycle while result_stall is low; a final byte that yields both
// a payload byte and the class report sends the payload byte first.
// byte_stall rises only when the queue is full. Reset clears the frame
// state, the queue pointers and the output valid; no clearing pass.

module frame_classifier_slip_decoder import fcsd_pkg::*; #(
	parameter int COUNT_WIDTH = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     byte_valid,
	output logic          byte_stall,
	input  wire in_item_t byte_data,
	output logic          result_valid,
	input  wire logic     result_stall,
	output out_item_t     result_data
);

	logic push, full, head_valid, pop;
	cmd_t push_cmd, head_cmd;

	// classify the frame and decode SLIP as each byte arrives
	fcsd_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full)
	);

	// hold pending work so the input waits on a stalled output only once the queue is full
	fcsd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	// expand each entry into one or two result items
	fcsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

`default_nettype wire

>>> verif/frame_classifier_slip_decoder_test.sv
`timescale 1ns / 1ps

module frame_classifier_slip_decoder_test;
	import fcsd_pkg::*;

	localparam int          CYCLE_LIMIT  = 2000000;
	localparam int          RANDOM_ITEMS = 925;
	localparam int          LONG_HOLD    = 300;
	localparam int          TAIL_CYCLES  = 20;
	localparam logic [15:0] COUNT_CEIL   = 16'hFFFF;

	typedef logic [7:0] byte_q_t[$];

	// Scoreboard: track the frame state of the classifier/decoder, turn each
	// accepted byte into the results it should cause, and match arriving
	// results against them in order.
	class frame_scoreboard;
		out_item_t   expected_results[$];
		int          mismatches;
		int          results_seen;
		logic [2:0]  position;
		logic        is_slip;
		logic        closed;
		logic        escaped;
		logic        seen_nonspace;
		logic        starts_json;
		logic        head_nontext;
		logic [15:0] payload_total;

		function new();
			mismatches = 0;
			results_seen = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			position = 3'd0;
			is_slip = 1'b0;
			closed = 1'b0;
			escaped = 1'b0;
			seen_nonspace = 1'b0;
			starts_json = 1'b0;
			head_nontext = 1'b0;
			payload_total = 16'd0;
		endfunction

		function out_item_t make_result(logic kind, logic [7:0] value, class_t cls,
				logic [15:0] count);
			out_item_t r;
			r.out_kind = kind;
			r.out_byte = value;
			r.frame_class = cls;
			r.decoded_count = count;
			r.run_end = 1'b0;
			return r;
		endfunction

		// Classify and decode one accepted byte; queue what it yields.
		function void note_byte(in_item_t item);
			logic [7:0] b;
			logic [2:0] pos;
			logic [7:0] value;
			logic       emit;
			logic       printable;
			class_t     cls;
			out_item_t  made[2];
			int         n;
			b = item.in_byte;
			pos = position;
			value = b;
			emit = 1'b0;
			n = 0;
			if (pos == 3'd0)
				is_slip = (b == FR_END);
			if (!seen_nonspace && !(b == CHR_SPACE || b == CHR_TAB ||
					b == CHR_CR || b == CHR_LF)) begin
				seen_nonspace = 1'b1;
				starts_json = (b == CHR_LBRACE) || (b == CHR_LBRACKET);
			end
			printable = (b >= CHR_SPACE && b <= CHR_TILDE) || b == CHR_TAB ||
				b == CHR_LF || b == CHR_CR;
			if (pos < HEAD_LEN && !printable)
				head_nontext = 1'b1;
			if (is_slip && pos != 3'd0 && !closed) begin
				if (escaped) begin
					escaped = 1'b0;
					if (b == FR_TEND)
						value = FR_END;
					else if (b == FR_TESC)
						value = FR_ESC;
					emit = 1'b1;
				end else if (b == FR_END) begin
					closed = 1'b1;
				end else if (b == FR_ESC) begin
					escaped = 1'b1;
				end else begin
					emit = 1'b1;
				end
			end
			if (emit) begin
				made[n] = make_result(KIND_BYTE, value, CLASS_SLIP, 16'd0);
				n++;
				if (payload_total != COUNT_CEIL)
					payload_total++;
			end
			if (pos < HEAD_LEN)
				position = pos + 3'd1;
			if (item.frame_end) begin
				if (is_slip)
					cls = CLASS_SLIP;
				else if (starts_json)
					cls = CLASS_JSON;
				else if (pos != 3'd0 && head_nontext)
					cls = CLASS_PROTO;
				else
					cls = CLASS_TEXT;
				made[n] = make_result(KIND_REPORT, 8'd0, cls, payload_total);
				n++;
				clear_frame();
			end
			if (n > 0)
				made[n - 1].run_end = 1'b1;
			for (int i = 0; i < n; i++)
				expected_results.push_back(made[i]);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none expected",
					results_seen));
				return;
			end
			want = expected_results.pop_front();
			if (got.out_kind !== want.out_kind)
				report_mismatch($sformatf("result %0d out_kind got %b want %b",
					results_seen, got.out_kind, want.out_kind));
			if (got.out_byte !== want.out_byte)
				report_mismatch($sformatf("result %0d out_byte got %02h want %02h",
					results_seen, got.out_byte, want.out_byte));
			if (got.frame_class !== want.frame_class)
				report_mismatch($sformatf("result %0d frame_class got %0d want %0d",
					results_seen, got.frame_class, want.frame_class));
			if (got.decoded_count !== want.decoded_count)
				report_mismatch($sformatf("result %0d decoded_count got %0d want %0d",
					results_seen, got.decoded_count, want.decoded_count));
			if (got.run_end !== want.run_end)
				report_mismatch($sformatf("result %0d run_end got %b want %b",
					results_seen, got.run_end, want.run_end));
		endtask

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_data = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result_data;

	int   send_gap_max = 10;
	int   recv_gap_max = 10;
	bit   hold_requested = 1'b0;
	int   cycle_count = 0;

	frame_scoreboard board = new();

	frame_classifier_slip_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: end the run as a failure once cycle_count passes CYCLE_LIMIT.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one byte and hold it until accepted. All TB-driven signals change
	// only at the rising edge, so sample the stall at the falling edge where
	// everything has settled; the item moves at the following rising edge.
	task automatic send_item(input logic [7:0] value, input logic last);
		int       gap;
		logic     blocked;
		in_item_t item;
		item.in_byte = value;
		item.frame_end = last;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= item;
		do begin
			@(negedge clk);
			blocked = (byte_stall !== 1'b0);
			@(posedge clk);
		end while (blocked);
		board.note_byte(item);
	endtask

	task automatic send_frame(input byte_q_t bytes);
		for (int i = 0; i < bytes.size(); i++)
			send_item(bytes[i], i == bytes.size() - 1);
	endtask

	// Drop valid and wait for every expected result to come back.
	task automatic wait_drained();
		byte_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// Bytes the classifier and decoder treat specially, plus the extremes.
	function automatic logic [7:0] notable_byte();
		case ($urandom_range(0, 14))
			0:       return FR_END;
			1:       return FR_ESC;
			2:       return FR_TEND;
			3:       return FR_TESC;
			4:       return CHR_SPACE;
			5:       return CHR_TAB;
			6:       return CHR_LF;
			7:       return CHR_CR;
			8:       return CHR_LBRACE;
			9:       return CHR_LBRACKET;
			10:      return CHR_TILDE;
			11:      return 8'h7F;
			12:      return 8'h1F;
			13:      return 8'h00;
			default: return 8'hFF;
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 2) == 0)
			return notable_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] space_byte();
		case ($urandom_range(0, 3))
			0:       return CHR_SPACE;
			1:       return CHR_TAB;
			2:       return CHR_CR;
			default: return CHR_LF;
		endcase
	endfunction

	// Build one frame: most often SLIP with random content, the rest
	// JSON-, protobuf- and text-like frames, single bytes and raw noise.
	function automatic byte_q_t random_frame();
		byte_q_t f;
		int      len;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				f.push_back(FR_END);
				len = $urandom_range(0, 12);
				repeat (len) begin
					case ($urandom_range(0, 7))
						0: begin
							f.push_back(FR_ESC);
							f.push_back(FR_TEND);
						end
						1: begin
							f.push_back(FR_ESC);
							f.push_back(FR_TESC);
						end
						2: begin
							f.push_back(FR_ESC);
							f.push_back(pick_byte());
						end
						default: f.push_back(8'($urandom_range(0, 255)));
					endcase
				end
				// close the payload, then trail a few bytes that must be ignored
				if ($urandom_range(0, 1) == 0) begin
					f.push_back(FR_END);
					repeat ($urandom_range(0, 3))
						f.push_back(pick_byte());
				end else if ($urandom_range(0, 3) == 0) begin
					f.push_back(FR_ESC);
				end
			end
			4: begin
				repeat ($urandom_range(0, 5))
					f.push_back(space_byte());
				f.push_back($urandom_range(0, 1) ? CHR_LBRACE : CHR_LBRACKET);
				repeat ($urandom_range(0, 8))
					f.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end
			5: begin
				len = $urandom_range(2, 8);
				repeat (len)
					f.push_back(pick_byte());
			end
			6: begin
				len = $urandom_range(1, 10);
				repeat (len)
					f.push_back($urandom_range(0, 4) == 0 ? space_byte() :
						8'($urandom_range(8'h20, 8'h7E)));
			end
			7: f.push_back(pick_byte());
			default: begin
				len = $urandom_range(1, 8);
				repeat (len)
					f.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		return f;
	endfunction

	// Result sink: stall for a random number of cycles before each result,
	// or for a long stretch when asked, then take the next result.
	initial begin : result_sink
		int        hold;
		logic      taken;
		out_item_t got;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_requested) begin
				hold_requested = 1'b0;
				hold = LONG_HOLD;
			end else begin
				hold = $urandom_range(0, recv_gap_max);
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do begin
				@(negedge clk);
				taken = (result_valid === 1'b1);
				got = result_data;
				@(posedge clk);
			end while (!taken);
			board.check_result(got);
		end
	end

	initial begin : stimulus
		byte_q_t frame;
		int      sent;
		bit      pressed;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-byte frames: a lone END, a lone NUL (never protobuf), a lone brace.
		send_frame('{FR_END});
		send_frame('{8'h00});
		send_frame('{CHR_LBRACE});
		// Both escapes, an escaped plain byte, a closing END and an ignored tail.
		send_frame('{FR_END, 8'h41, FR_ESC, FR_TEND, FR_ESC, FR_TESC,
			FR_ESC, 8'h55, FR_END, 8'h77});
		// ESC on the final byte is dropped.
		send_frame('{FR_END, FR_ESC});
		// JSON behind leading whitespace.
		send_frame('{CHR_SPACE, CHR_LF, CHR_LBRACKET});
		// Short binary frame, then a text frame whose bad byte lies past the head.
		send_frame('{8'h41, 8'h00});
		send_frame('{8'h41, 8'h42, 8'h43, 8'h44, 8'hFF});
		wait_drained();

		sent = 0;
		pressed = 1'b0;
		send_gap_max = 10;
		recv_gap_max = 10;
		while (sent < RANDOM_ITEMS) begin
			// Switch idling now and then, leaving stretches with no gaps at all.
			if ($urandom_range(0, 11) == 0) begin
				send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
				recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
			end
			if (!pressed && sent >= RANDOM_ITEMS / 3) begin
				// Hold the result side off while bytes keep coming, so the
				// queue fills and the input stalls. Keep the payload free of
				// END and ESC so every payload byte yields a result.
				pressed = 1'b1;
				hold_requested = 1'b1;
				send_gap_max = 0;
				frame.delete();
				frame.push_back(FR_END);
				repeat (30)
					frame.push_back(8'($urandom_range(0, 8'hBF)));
				send_frame(frame);
				sent += frame.size();
				send_gap_max = 10;
			end else begin
				frame = random_frame();
				send_frame(frame);
				sent += frame.size();
			end
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/fcsd_pkg.sv
hw/rtl/fcsd_front.sv
hw/rtl/fcsd_queue.sv
hw/rtl/fcsd_back.sv
hw/rtl/frame_classifier_slip_decoder.sv
verif/frame_classifier_slip_decoder_test.sv
